/* design/dtli_pkg.sv */
// Shared types and constants for the descending table interpolator.
`timescale 1ns / 1ps
package dtli_pkg;
   localparam int TableDepth = 128;
   localparam int IdxW = $clog2(TableDepth);
   localparam int XW = 32;
   localparam int YW = 24;
   localparam int QueueDepth = 2;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_ABOVE = 2'd1;
   localparam logic [1:0] CLAMP_BELOW = 2'd2;
   localparam logic [1:0] CLAMP_WRACK = 2'd3;

   localparam logic [0:0] CSR_ENTRIES_USED = 1'b0;

   typedef struct packed {
      logic          is_eval;
      logic [6:0]    index;
      logic [XW-1:0] ex;
      logic [YW-1:0] ey;
      logic [XW-1:0] qx;
   } cmd_type;
endpackage

/* design/dtli_front.sv */
// Front end: takes commands and queues them toward the search engine.
`timescale 1ns / 1ps
module dtli_front import dtli_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          busy,
   input  cmd_type       cmd_in,
   output logic          q_valid,
   output cmd_type       q_head,
   input  logic          q_pop,
   output logic          q_full
);
   cmd_type slot_ff [QueueDepth];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push;

   assign push = start && !busy;
   assign q_full = (count_ff == 2'(QueueDepth));
   assign q_valid = (count_ff != 2'd0);
   assign q_head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= cmd_in;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QueueDepth)) else $error("queue count out of range");
`endif
endmodule

/* design/dtli_back.sv */
// Back end: table memory, binary search and serial division.
`timescale 1ns / 1ps
module dtli_back import dtli_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    entries_used,
   input  logic          q_valid,
   input  cmd_type       q_head,
   output logic          q_pop,
   output logic          idle,
   output logic          rsp_valid,
   output logic [YW-1:0] rsp_result_y,
   output logic [6:0]    rsp_segment_index,
   output logic [1:0]    rsp_clamp_status
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RD0   = 9'b000000010,
      S_RDL   = 9'b000000100,
      S_CHECK = 9'b000001000,
      S_SRCH  = 9'b000010000,
      S_RDA   = 9'b000100000,
      S_RDB   = 9'b001000000,
      S_MUL   = 9'b010000000,
      S_DIV   = 9'b100000000
   } state_type;

   localparam int CapI = (TableDepth < 128) ? TableDepth : 128;
   localparam int PW = YW + XW;

   logic [XW-1:0] mem_x [TableDepth];
   logic [YW-1:0] mem_y [TableDepth];
   logic [XW-1:0] rdx_ff;
   logic [YW-1:0] rdy_ff;
   logic [IdxW-1:0] raddr;
   logic mem_we;

   state_type state_ff, state_in;
   cmd_type cmd_ff;
   logic [IdxW-1:0] lo_ff, lo_in, hi_ff, hi_in, last_ff;
   logic [XW-1:0] xa_ff, xa_in, x0_ff, x0_in;
   logic [YW-1:0] ya_ff, ya_in, y0_ff, y0_in;
   logic [YW-1:0] mag_ff, mag_in;
   logic up_ff, up_in;
   logic [XW-1:0] d_ff, d_in, t_ff, t_in;
   logic [PW-1:0] num_ff, num_in;
   logic [XW:0] rem_ff, rem_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [6:0] cnt_ff, cnt_in;
   logic out_v_ff, out_v_in;
   logic [YW-1:0] out_y_ff, out_y_in;
   logic [6:0] out_i_ff, out_i_in;
   logic [1:0] out_s_ff, out_s_in;

   logic [8:0] n_used;
   logic [IdxW-1:0] mid;
   logic srch_done;
   logic [XW:0] rem_sh, rem_sub;
   logic [PW:0] sum;
   logic [YW:0] res;

   assign n_used = (entries_used < 8'd2) ? 9'd2 :
                   ({1'b0, entries_used} > 9'(CapI)) ? 9'(CapI) : {1'b0, entries_used};
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign srch_done = ((hi_ff - lo_ff) <= IdxW'(1));
   assign mem_we = (state_ff == S_IDLE) && q_valid && !q_head.is_eval
                   && ({1'b0, q_head.index} < 8'(TableDepth));

   // read address for the word that lands in rdx_ff/rdy_ff next cycle
   always_comb begin
      case (state_ff)
         S_IDLE:  raddr = '0;
         S_RD0:   raddr = last_ff;
         S_CHECK: raddr = srch_done ? lo_ff : mid;
         S_RDA:   raddr = lo_ff + IdxW'(1);
         default: raddr = lo_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_x[q_head.index[IdxW-1:0]] <= q_head.ex;
         mem_y[q_head.index[IdxW-1:0]] <= q_head.ey;
      end
      rdx_ff <= mem_x[raddr];
      rdy_ff <= mem_y[raddr];
   end

   assign rem_sh = {rem_ff[XW-1:0], num_ff[PW-1]};
   assign rem_sub = rem_sh - {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff; hi_in = hi_ff;
      xa_in = xa_ff; ya_in = ya_ff; x0_in = x0_ff; y0_in = y0_ff;
      mag_in = mag_ff; up_in = up_ff; d_in = d_ff; t_in = t_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      out_v_in = 1'b0; out_y_in = out_y_ff; out_i_in = out_i_ff; out_s_in = out_s_ff;
      q_pop = 1'b0;
      sum = '0; res = '0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!q_head.is_eval) begin
                  out_v_in = 1'b1; out_y_in = '0;
                  out_i_in = q_head.index; out_s_in = CLAMP_WRACK;
               end else begin
                  state_in = S_RD0;
               end
            end
         end
         S_RD0: begin
            x0_in = rdx_ff; y0_in = rdy_ff; state_in = S_RDL;
         end
         S_RDL: begin
            lo_in = '0; hi_in = last_ff;
            if (cmd_ff.qx > x0_ff) begin
               out_v_in = 1'b1; out_y_in = y0_ff; out_i_in = '0;
               out_s_in = CLAMP_ABOVE; state_in = S_IDLE;
            end else if (cmd_ff.qx <= rdx_ff) begin
               out_v_in = 1'b1; out_y_in = rdy_ff; out_i_in = 7'(last_ff);
               out_s_in = CLAMP_BELOW; state_in = S_IDLE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = srch_done ? S_RDA : S_SRCH;
         end
         S_SRCH: begin
            if (rdx_ff >= cmd_ff.qx) lo_in = mid; else hi_in = mid;
            state_in = S_CHECK;
         end
         S_RDA: begin
            xa_in = rdx_ff; ya_in = rdy_ff; state_in = S_RDB;
         end
         S_RDB: begin
            d_in = xa_ff - rdx_ff;
            t_in = xa_ff - cmd_ff.qx;
            up_in = rdy_ff >= ya_ff;
            mag_in = (rdy_ff >= ya_ff) ? rdy_ff - ya_ff : ya_ff - rdy_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            num_in = PW'(mag_ff) * PW'(t_ff) + PW'(d_ff >> 1);
            rem_in = '0; quo_in = '0; cnt_in = 7'(PW);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (!rem_sub[XW]) begin
               rem_in = rem_sub; quo_in = {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh; quo_in = {quo_ff[PW-2:0], 1'b0};
            end
            num_in = {num_ff[PW-2:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               sum = up_ff ? {1'b0, PW'(ya_ff)} + {1'b0, quo_in}
                           : {1'b0, PW'(ya_ff)} - {1'b0, quo_in};
               if (sum[PW]) res = '0;
               else if (sum[PW-1:YW] != '0) res = {1'b0, {YW{1'b1}}};
               else res = {1'b0, sum[YW-1:0]};
               out_v_in = 1'b1; out_y_in = res[YW-1:0];
               out_i_in = 7'(lo_ff); out_s_in = CLAMP_NONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid) begin
         cmd_ff <= q_head;
         last_ff <= IdxW'(n_used - 9'd1);
      end
      lo_ff <= lo_in; hi_ff <= hi_in;
      xa_ff <= xa_in; ya_ff <= ya_in; x0_ff <= x0_in; y0_ff <= y0_in;
      mag_ff <= mag_in; up_ff <= up_in; d_ff <= d_in; t_ff <= t_in;
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; cnt_ff <= cnt_in;
      out_y_ff <= out_y_in; out_i_ff <= out_i_in; out_s_ff <= out_s_in;
   end

   assign idle = (state_ff == S_IDLE) && !q_valid;
   assign rsp_valid = out_v_ff;
   assign rsp_result_y = out_y_ff;
   assign rsp_segment_index = out_i_ff;
   assign rsp_clamp_status = out_s_ff;

`ifndef SYNTHESIS
   a_bracket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (lo_ff < hi_ff)) else $error("search bracket lost");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE)) else $error("pop while busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid) || $past(state_ff) == S_IDLE)
      else $error("unexpected response");
`endif
endmodule

/* design/descending_table_linear_interpolator.sv */
// Top level of the descending table linear interpolator.
`timescale 1ns / 1ps
//  channel  ports             handshake
//  request  req_*             start & !busy
//  result   rsp_*             rsp_valid, one cycle, no backpressure
//  config   csr_* / APB       psel & penable & pwrite
// A write word is acknowledged on rsp_valid once the back end pops it from the queue, a
// clamped evaluation once both end entries have been read. An interpolated evaluation
// reads the two end entries, runs the binary search (up to 7 steps at 128 entries),
// loads the operands and runs the bit-serial divider (one quotient bit per cycle); the
// result is then registered and strobed on rsp_valid.
// Reset is synchronous; entries_used returns to 100, table contents stay undefined.
// The two-entry command queue lets a new command be taken while one is in work;
// busy rises when the queue is full.
module descending_table_linear_interpolator import dtli_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_type,
   input  logic [6:0]    req_entry_index,
   input  logic [XW-1:0] req_entry_x,
   input  logic [YW-1:0] req_entry_y,
   input  logic [XW-1:0] req_query_x,
   output logic          rsp_valid,
   output logic [YW-1:0] rsp_result_y,
   output logic [6:0]    rsp_segment_index,
   output logic [1:0]    rsp_clamp_status,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);
   cmd_type cmd, head;
   logic q_valid, q_pop, q_full, idle;
   logic [7:0] entries_ff;

   assign cmd = '{is_eval: req_type, index: req_entry_index, ex: req_entry_x,
                  ey: req_entry_y, qx: req_query_x};
   assign busy = q_full;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_ENTRIES_USED) ? {24'd0, entries_ff} : 32'd0;

   // hold the entry count; write only at the access phase
   always_ff @(posedge clock) begin
      if (reset) entries_ff <= 8'd100;
      else if (psel && penable && pwrite && paddr[2] == CSR_ENTRIES_USED)
         entries_ff <= pwdata[7:0];
   end

   dtli_front u_front (.clock, .reset, .start, .busy, .cmd_in(cmd),
      .q_valid, .q_head(head), .q_pop, .q_full);

   dtli_back u_back (.clock, .reset, .entries_used(entries_ff), .q_valid,
      .q_head(head), .q_pop, .idle, .rsp_valid, .rsp_result_y,
      .rsp_segment_index, .rsp_clamp_status);

`ifndef SYNTHESIS
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(idle) && idle |-> !rsp_valid) else $error("response while idle");
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_valid) else $error("busy with empty queue");
   a_pready: assert property (@(posedge clock) pready) else $error("pready low");
`endif
endmodule
